// ===== hdl/bba_pkg.sv =====
`default_nettype none
package bba_pkg;
  localparam int PageBits  = 12;
  localparam int TreeOrder = 10;
  localparam int NodeCount = 2047;
  localparam int IdxW      = 11;
  localparam int AvW       = 4;
  localparam int OffW      = 22;
  localparam int SizeW     = 23;
  localparam int StW       = 3;
  localparam int OrdW      = 4;
  localparam int DepW      = 4;

  localparam logic [StW-1:0] ST_OK       = 3'd0;
  localparam logic [StW-1:0] ST_ZERO     = 3'd1;
  localparam logic [StW-1:0] ST_TOOBIG   = 3'd2;
  localparam logic [StW-1:0] ST_NOROOM   = 3'd3;
  localparam logic [StW-1:0] ST_BADFREE  = 3'd4;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // One node word: split bit on top, avail code below.
  typedef struct packed {
    logic           split;
    logic [AvW-1:0] avail;
  } node_t;

  function automatic logic [AvW-1:0] larger(input logic [AvW-1:0] a,
                                            input logic [AvW-1:0] b);
    return (a > b) ? a : b;
  endfunction
endpackage
`default_nettype wire

// ===== hdl/bba_ram.sv =====
`default_nettype none
module bba_ram #(
  parameter int Depth = 2048,
  parameter int AddrW = 11,
  parameter int DataW = 5
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AddrW-1:0] waddr,
  input  wire logic [DataW-1:0] wdata,
  input  wire logic [AddrW-1:0] raddr,
  output logic      [DataW-1:0] rdata
);
  logic [DataW-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hdl/buddy_block_allocator_top.sv =====
// Binary buddy allocator over a 4 MiB heap of 4 KiB pages.
// Input channel (in_valid/in_ready): one beat carries in_opcode (0 allocate,
// 1 free), in_request_size and in_free_offset. Result channel
// (out_valid/out_ready): one beat per input beat with out_block_offset and
// out_status (0 ok, 1 zero size, 2 too big, 3 no room, 4 bad free).
// The tree lives in a single-port-write, single-port-read node memory that
// the sequencer visits one node at a time. On the way down an allocate reads
// each node on its path and then either reads both its children or, where it
// splits a free block, writes both children free; a free reads only the nodes
// on its path. On the way up each level reads both children of the path node
// and rewrites it. A zero or oversized request is answered without reading
// the tree, a full root after the root read alone. One item is in flight at
// a time; in_ready is low while it is worked on and rises again in the cycle
// its result is offered. After reset the node memory is swept once, writing
// the root free and all other nodes empty; no input is taken during the sweep.
// A finished result waits in the output register; if the receiver stalls,
// the next item is accepted but its result is held until the slot empties.
`default_nettype none
module buddy_block_allocator_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_opcode,
  input  wire logic [22:0] in_request_size,
  input  wire logic [21:0] in_free_offset,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [21:0] out_block_offset,
  output logic      [2:0]  out_status
);
  localparam int IW = bba_pkg::IdxW;
  localparam int AW = bba_pkg::AvW;

  typedef enum logic [10:0] {
    S_CLR   = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_RD    = 11'b00000000100,  // issue read of current node
    S_ND    = 11'b00000001000,  // node data back
    S_RDC0  = 11'b00000010000,  // left child data back, or write it after a split
    S_RDC1  = 11'b00000100000,  // write right child after a split
    S_CH    = 11'b00001000000,  // both children in hand, descend decision
    S_UPRD  = 11'b00010000000,  // ascend: read left child of path node
    S_UPC0  = 11'b00100000000,
    S_UPC1  = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [IW-1:0] clr_r, clr_nxt;
  logic op_r, op_nxt;
  logic [21:0] off_r, off_nxt;
  logic [3:0] k_r, k_nxt;          // requested order
  logic [3:0] o_r, o_nxt;          // current order
  logic [IW-1:0] idx_r, idx_nxt;
  logic [21:0] pos_r, pos_nxt;
  logic [3:0] dep_r, dep_nxt;
  logic [IW-1:0] path_r [bba_pkg::TreeOrder+1];
  logic [IW-1:0] path_nxt [bba_pkg::TreeOrder+1];
  logic [2:0] st_r, st_nxt;
  bba_pkg::node_t nd_r, nd_nxt;     // current node
  bba_pkg::node_t c0_r, c0_nxt;     // left child
  logic [AW-1:0] need_r, need_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [21:0] out_off_r, out_off_nxt;
  logic [2:0] out_st_r, out_st_nxt;

  logic we;
  logic [IW-1:0] waddr, raddr;
  bba_pkg::node_t wdata, rdata;
  logic [4:0] wbits, rbits;

  assign wbits = wdata;
  assign rdata = bba_pkg::node_t'(rbits);

  bba_ram #(.Depth(1 << IW), .AddrW(IW), .DataW(AW + 1)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wbits),
    .raddr(raddr), .rdata(rbits)
  );

  // Order of request: smallest k with 2^(PageBits+k) >= size.
  logic [3:0] k_calc;
  logic       big_calc;
  always_comb begin
    k_calc   = '0;
    big_calc = 1'b1;
    for (int i = bba_pkg::TreeOrder; i >= 0; i--) begin
      if ({1'b0, in_request_size} <= (24'd1 << (bba_pkg::PageBits + i))) begin
        k_calc   = 4'(i);
        big_calc = 1'b0;
      end
    end
  end

  logic [IW-1:0] c0_idx, c1_idx;
  logic [21:0] half;
  logic        child_ok;
  assign c0_idx   = IW'({idx_r, 1'b0} + 12'd1);
  assign c1_idx   = IW'({idx_r, 1'b0} + 12'd2);
  assign child_ok = ({1'b0, idx_r, 1'b0} + 13'd2) < 13'(bba_pkg::NodeCount);
  assign half     = 22'(23'd1 << (bba_pkg::PageBits + 32'(o_r) - 1));

  logic [IW-1:0] up_p;
  logic [IW-1:0] up_c0, up_c1;
  logic [3:0] up_op;
  assign up_p  = path_r[dep_r - 4'd1];
  assign up_c0 = IW'({up_p, 1'b0} + 12'd1);
  assign up_c1 = IW'({up_p, 1'b0} + 12'd2);
  assign up_op = 4'(bba_pkg::TreeOrder) - (dep_r - 4'd1);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_block_offset = out_off_r;
  assign out_status = out_st_r;

  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r; op_nxt = op_r; off_nxt = off_r; k_nxt = k_r; o_nxt = o_r;
    idx_nxt = idx_r; pos_nxt = pos_r; dep_nxt = dep_r; st_nxt = st_r;
    nd_nxt = nd_r; c0_nxt = c0_r; need_nxt = need_r;
    path_nxt = path_r;
    out_valid_nxt = out_valid_r; out_off_nxt = out_off_r; out_st_nxt = out_st_r;
    we = 1'b0; waddr = idx_r; wdata = '0; raddr = idx_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    case (state_r)
      S_CLR: begin
        we = 1'b1; waddr = clr_r;
        wdata.split = 1'b0;
        wdata.avail = (clr_r == '0) ? AW'(bba_pkg::TreeOrder + 1) : '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          op_nxt = in_opcode; off_nxt = in_free_offset;
          k_nxt = k_calc; need_nxt = AW'(k_calc) + 1'b1;
          o_nxt = 4'(bba_pkg::TreeOrder); idx_nxt = '0; pos_nxt = '0;
          dep_nxt = '0; st_nxt = bba_pkg::ST_OK;
          if (in_opcode == bba_pkg::OP_ALLOC && in_request_size == '0) begin
            st_nxt = bba_pkg::ST_ZERO; state_nxt = S_DONE;
          end else if (in_opcode == bba_pkg::OP_ALLOC && big_calc) begin
            st_nxt = bba_pkg::ST_TOOBIG; state_nxt = S_DONE;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        raddr = idx_r; state_nxt = S_ND;
      end
      S_ND: begin
        nd_nxt = rdata;
        if (op_r == bba_pkg::OP_ALLOC) begin
          if (dep_r == '0 && rdata.avail < need_r) begin
            st_nxt = bba_pkg::ST_NOROOM; state_nxt = S_DONE;
          end else if (o_r == k_r) begin
            we = 1'b1; waddr = idx_r; wdata.split = rdata.split; wdata.avail = '0;
            st_nxt = bba_pkg::ST_OK; state_nxt = S_UPRD;
          end else if (o_r == '0 || !child_ok) begin
            st_nxt = bba_pkg::ST_NOROOM; state_nxt = S_UPRD;
          end else if (!rdata.split) begin
            // Split: mark node split, children come out free at order o-1.
            we = 1'b1; waddr = idx_r; wdata.split = 1'b1; wdata.avail = rdata.avail;
            state_nxt = S_RDC0;
            c0_nxt.split = 1'b0; c0_nxt.avail = AW'(o_r);
            nd_nxt.split = 1'b0;
          end else begin
            raddr = c0_idx; state_nxt = S_RDC0; nd_nxt.split = 1'b1;
          end
        end else begin
          if (!rdata.split) begin
            if ({off_r} != pos_r || rdata.avail != '0) begin
              st_nxt = bba_pkg::ST_BADFREE; state_nxt = S_DONE;
            end else begin
              we = 1'b1; waddr = idx_r; wdata.split = 1'b0;
              wdata.avail = AW'(o_r) + 1'b1;
              state_nxt = S_UPRD;
            end
          end else if (o_r == '0 || !child_ok) begin
            st_nxt = bba_pkg::ST_BADFREE; state_nxt = S_DONE;
          end else begin
            path_nxt[dep_r] = idx_r; dep_nxt = dep_r + 1'b1;
            if (off_r >= pos_r + half) begin
              idx_nxt = c1_idx; pos_nxt = pos_r + half;
            end else begin
              idx_nxt = c0_idx;
            end
            o_nxt = o_r - 1'b1; state_nxt = S_RD;
          end
        end
      end
      S_RDC0: begin
        // nd_r.split low here means a fresh split: write both children.
        if (!nd_r.split) begin
          we = 1'b1; waddr = c0_idx; wdata = c0_r;
          nd_nxt.split = 1'b1; state_nxt = S_RDC1;
        end else begin
          c0_nxt = rdata; raddr = c1_idx; state_nxt = S_CH;
        end
      end
      S_RDC1: begin
        we = 1'b1; waddr = c1_idx; wdata = c0_r;
        raddr = c1_idx; state_nxt = S_CH;
        // Data for c1 equals c0; read is not needed.
        nd_nxt.avail = '1;
      end
      S_CH: begin
        bba_pkg::node_t c1;
        c1 = (nd_r.avail == '1 && c0_r.avail == AW'(o_r)) ? c0_r : rdata;
        path_nxt[dep_r] = idx_r; dep_nxt = dep_r + 1'b1; o_nxt = o_r - 1'b1;
        if (c0_r.avail >= need_r) begin
          idx_nxt = c0_idx; state_nxt = S_RD;
        end else if (c1.avail >= need_r) begin
          idx_nxt = c1_idx; pos_nxt = pos_r + half; state_nxt = S_RD;
        end else begin
          st_nxt = bba_pkg::ST_NOROOM; state_nxt = S_UPRD;
        end
      end
      S_UPRD: begin
        if (dep_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          raddr = up_c0; state_nxt = S_UPC0;
        end
      end
      S_UPC0: begin
        c0_nxt = rdata; raddr = up_c1; state_nxt = S_UPC1;
      end
      S_UPC1: begin
        we = 1'b1; waddr = up_p;
        if (op_r == bba_pkg::OP_FREE && c0_r.avail == AW'(up_op) &&
            rdata.avail == AW'(up_op) && !c0_r.split && !rdata.split) begin
          wdata.split = 1'b0; wdata.avail = AW'(up_op) + 1'b1;
        end else begin
          wdata.split = 1'b1; wdata.avail = bba_pkg::larger(c0_r.avail, rdata.avail);
        end
        dep_nxt = dep_r - 1'b1; state_nxt = S_UPRD;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1; out_st_nxt = st_r;
          out_off_nxt = (st_r == bba_pkg::ST_OK && op_r == bba_pkg::OP_ALLOC) ?
                        pos_r : '0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR; clr_r <= '0; out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; clr_r <= clr_nxt; out_valid_r <= out_valid_nxt;
    end
    op_r <= op_nxt; off_r <= off_nxt; k_r <= k_nxt; o_r <= o_nxt;
    idx_r <= idx_nxt; pos_r <= pos_nxt; dep_r <= dep_nxt; st_r <= st_nxt;
    nd_r <= nd_nxt; c0_r <= c0_nxt; need_r <= need_nxt; path_r <= path_nxt;
    out_off_r <= out_off_nxt; out_st_r <= out_st_nxt;
  end
endmodule
`default_nettype wire
